FILE: hdl/apc_pkg.sv
// apc_pkg: shared types and constants of the arithmetic progression run compactor
// no dependencies
package apc_pkg;

    localparam int unsigned FIELD_W    = 32;
    localparam int unsigned MAX_RANGES = 3;
    localparam int unsigned CNT_W      = 2;   // holds 0 .. MAX_RANGES
    localparam int unsigned QDEPTH     = 4;

    typedef struct packed {
        logic [FIELD_W-1:0] range_first;
        logic [FIELD_W-1:0] range_last;
        logic [FIELD_W-1:0] range_stride;
    } t_range;

    // all ranges caused by one accepted request
    typedef struct packed {
        logic                        last;
        logic [CNT_W-1:0]            cnt;
        t_range [MAX_RANGES-1:0]     rng;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_push;

    typedef struct packed {
        logic   empty;
        t_entry head;
    } t_head;

endpackage

FILE: hdl/apc_if.sv
// apc_if: valid/ready channel interfaces for the request and range streams
// depends on: nothing
interface apc_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] ident;
    logic               last_in;

    modport source (output valid, output ident, output last_in, input ready);
    modport sink   (input valid, input ident, input last_in, output ready);
endinterface

interface apc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] range_first;
    logic signed [31:0] range_last;
    logic        [31:0] range_stride;
    logic               final_out;

    modport source (output valid, output range_first, output range_last,
                    output range_stride, output final_out, input ready);
    modport sink   (input valid, input range_first, input range_last,
                    input range_stride, input final_out, output ready);
endinterface

FILE: hdl/apc_front.sv
// apc_front: accepts identifiers, tracks run and pending singles, builds range entries
// depends on: apc_pkg, apc_in_if
module apc_front
    import apc_pkg::*;
#(
    parameter int ID_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    apc_in_if.sink      i_in,
    input  logic        i_full,
    output t_push       o_push
);

    logic                r_run_open;
    logic [ID_WIDTH-1:0] r_run_begin;
    logic [ID_WIDTH-1:0] r_run_stop;
    logic [ID_WIDTH-1:0] r_run_delta;
    logic [1:0]          r_pend_cnt;
    logic [ID_WIDTH-1:0] r_pend_older;
    logic [ID_WIDTH-1:0] r_pend_newer;
    logic [ID_WIDTH-1:0] r_pend_delta;   // newer - older while two are pending

    logic                n_run_open;
    logic [ID_WIDTH-1:0] n_run_begin;
    logic [ID_WIDTH-1:0] n_run_stop;
    logic [ID_WIDTH-1:0] n_run_delta;
    logic [1:0]          n_pend_cnt;
    logic [ID_WIDTH-1:0] n_pend_older;
    logic [ID_WIDTH-1:0] n_pend_newer;
    logic [ID_WIDTH-1:0] n_pend_delta;

    logic [ID_WIDTH-1:0] x;
    logic [ID_WIDTH-1:0] base;
    logic [ID_WIDTH-1:0] diff;
    logic                step_match;
    logic                dup;
    logic                accept;
    t_entry              ent;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && i_in.ready;

    assign x          = ID_WIDTH'($unsigned(i_in.ident));
    // latest identifier seen and the step it would have to continue
    assign base       = r_run_open ? r_run_stop : r_pend_newer;
    assign diff       = x - base;
    assign step_match = diff == (r_run_open ? r_run_delta : r_pend_delta);
    assign dup        = (r_run_open || (r_pend_cnt != 2'd0)) && (x == base);

    always_comb begin
        n_run_open   = r_run_open;
        n_run_begin  = r_run_begin;
        n_run_stop   = r_run_stop;
        n_run_delta  = r_run_delta;
        n_pend_cnt   = r_pend_cnt;
        n_pend_older = r_pend_older;
        n_pend_newer = r_pend_newer;
        n_pend_delta = r_pend_delta;
        ent          = '0;
        ent.last     = i_in.last_in;

        if (!dup) begin
            if (r_run_open) begin
                if (step_match) begin
                    n_run_stop = x;
                end else begin
                    ent.rng[ent.cnt] = '{FIELD_W'(r_run_begin), FIELD_W'(r_run_stop),
                                         FIELD_W'(r_run_delta)};
                    ent.cnt      = ent.cnt + 2'd1;
                    n_run_open   = 1'b0;
                    n_pend_newer = x;
                    n_pend_cnt   = 2'd1;
                end
            end else if (r_pend_cnt == 2'd0) begin
                n_pend_newer = x;
                n_pend_cnt   = 2'd1;
            end else if (r_pend_cnt == 2'd1) begin
                n_pend_older = r_pend_newer;
                n_pend_newer = x;
                n_pend_delta = diff;
                n_pend_cnt   = 2'd2;
            end else begin
                if (step_match) begin
                    n_run_open  = 1'b1;
                    n_run_begin = r_pend_older;
                    n_run_stop  = x;
                    n_run_delta = diff;
                    n_pend_cnt  = 2'd0;
                end else begin
                    ent.rng[ent.cnt] = '{FIELD_W'(r_pend_older), FIELD_W'(r_pend_older),
                                         FIELD_W'(1)};
                    ent.cnt      = ent.cnt + 2'd1;
                    n_pend_older = r_pend_newer;
                    n_pend_newer = x;
                    n_pend_delta = diff;
                end
            end
        end

        // flush on the last identifier of a list
        if (i_in.last_in) begin
            if (n_run_open) begin
                ent.rng[ent.cnt] = '{FIELD_W'(n_run_begin), FIELD_W'(n_run_stop),
                                     FIELD_W'(n_run_delta)};
                ent.cnt = ent.cnt + 2'd1;
            end
            if (n_pend_cnt[1]) begin
                ent.rng[ent.cnt] = '{FIELD_W'(n_pend_older), FIELD_W'(n_pend_older),
                                     FIELD_W'(1)};
                ent.cnt = ent.cnt + 2'd1;
            end
            if (n_pend_cnt != 2'd0) begin
                ent.rng[ent.cnt] = '{FIELD_W'(n_pend_newer), FIELD_W'(n_pend_newer),
                                     FIELD_W'(1)};
                ent.cnt = ent.cnt + 2'd1;
            end
            n_run_open = 1'b0;
            n_pend_cnt = 2'd0;
        end
    end

    assign o_push.valid = accept && (ent.cnt != 2'd0);
    assign o_push.entry = ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_open <= 1'b0;
            r_pend_cnt <= 2'd0;
        end else if (accept) begin
            r_run_open <= n_run_open;
            r_pend_cnt <= n_pend_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_run_begin  <= n_run_begin;
            r_run_stop   <= n_run_stop;
            r_run_delta  <= n_run_delta;
            r_pend_older <= n_pend_older;
            r_pend_newer <= n_pend_newer;
            r_pend_delta <= n_pend_delta;
        end
    end

endmodule

FILE: hdl/apc_queue.sv
// apc_queue: short fifo of range entries between front and back
// depends on: apc_pkg
module apc_queue
    import apc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    input  logic  i_pop,
    output logic  o_full,
    output t_head o_head
);

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_QW = $clog2(QDEPTH + 1);

    t_entry             r_mem [QDEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_QW-1:0]  r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full       = r_count == CNT_QW'(QDEPTH);
    assign o_head.empty = r_count == '0;
    assign o_head.head  = r_mem[r_rd_ptr];
    assign do_push      = i_push.valid && !o_full;
    assign do_pop       = i_pop && !o_head.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_QW'(1);
            end else if (!do_push && do_pop) begin
                r_count <= r_count - CNT_QW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.entry;
        end
    end

endmodule

FILE: hdl/apc_back.sv
// apc_back: walks the ranges of each queued entry into the output register
// depends on: apc_pkg, apc_out_if
module apc_back
    import apc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_head    i_head,
    output logic     o_pop,
    apc_out_if.source o_out
);

    logic [CNT_W-1:0] r_sel;
    logic             r_valid;
    t_range           r_rng;
    logic             r_final;

    logic             load;
    logic             at_end;

    assign load   = !i_head.empty && (!r_valid || o_out.ready);
    assign at_end = r_sel == (i_head.head.cnt - 2'd1);
    assign o_pop  = load && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sel   <= at_end ? '0 : r_sel + 2'd1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rng   <= i_head.head.rng[r_sel];
            r_final <= i_head.head.last && at_end;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.range_first  = $signed(r_rng.range_first);
    assign o_out.range_last   = $signed(r_rng.range_last);
    assign o_out.range_stride = r_rng.range_stride;
    assign o_out.final_out    = r_final;

endmodule

FILE: hdl/arith_progression_run_compactor.sv
// arith_progression_run_compactor: top level, front classifier, entry queue, range emitter
// depends on: apc_pkg, apc_if, apc_front, apc_queue, apc_back
//
// usage
//   i_in carries signed identifiers (ident) with last_in on the
//   final one of a list. o_out carries ranges (range_first, range_last,
//   range_stride) and final_out on the last range of a list.
//   a request is taken at a rising edge with valid and ready both high.
//   three or more identifiers with a common difference come out as one range,
//   the rest as single ranges with step 1; a repeat of the latest identifier
//   is dropped. a request marked last flushes the open run and pending singles.
// throughput
//   one identifier per cycle is accepted while the queue is not full; a range
//   passes through the queue and the output register after the request that
//   closed it. the front does one add and compare per request. the back emits
//   one range per cycle while the receiver is ready; a flush of up to three
//   ranges is absorbed by the entry queue (four entries).
// reset and stall
//   synchronous active-low reset empties run state, queue and output register.
//   while the receiver stalls, the output holds; the queue fills and i_in.ready
//   drops only when it is full.
module arith_progression_run_compactor
    import apc_pkg::*;
#(
    parameter int ID_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    apc_in_if.sink    i_in,
    apc_out_if.source o_out
);

    t_push push;     // front -> queue
    t_head head;     // queue -> back
    logic  full;
    logic  pop;

    // classify identifiers and build range entries
    apc_front #(
        .ID_WIDTH (ID_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push)
    );

    // decouples front from a stalled output
    apc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (full),
        .o_head  (head)
    );

    // one range per cycle into the output register unless the receiver stalls
    apc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

FILE: hdl/apc_checker.sv
// apc_checker: port-level assertions on the range stream, bound to the top level
// depends on: arith_progression_run_compactor
module apc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [31:0] i_step
);

    // a range waiting on the receiver stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("range request dropped while stalled");

    // duplicates never reach a range, so a step is never zero
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_step != 32'd0)
        else $error("range with zero step");

    // reset empties the output register
    a_rst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_valid)
        else $error("range offered right after reset");

endmodule

bind arith_progression_run_compactor apc_checker u_apc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out.valid),
    .i_ready (o_out.ready),
    .i_step  (o_out.range_stride)
);

FILE: test/apc_range_checker.sv
`timescale 1ns / 100ps
// apc_range_checker: predicts the ranges of the run compactor from accepted requests
// and compares them, field by field, with the ranges that leave the block
// depends on: apc_pkg, apc_if
module apc_range_checker
    import apc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    apc_in_if    i_req,
    apc_out_if   i_rng,
    output int   o_fail_count,
    output int   o_outstanding
);

    typedef struct packed {
        t_range rng;
        logic   fin;
    } t_range_exp;

    t_range_exp  range_q[$];

    // predicted compactor state
    logic        run_open;
    logic [31:0] run_first;
    logic [31:0] run_last;
    logic [31:0] run_step;
    int unsigned held_cnt;
    logic [31:0] held_old;
    logic [31:0] held_new;

    function automatic t_range_exp make_range(input logic [31:0] first,
                                              input logic [31:0] stop,
                                              input logic [31:0] step);
        t_range_exp r;
        r.rng.range_first  = first;
        r.rng.range_last   = stop;
        r.rng.range_stride = step;
        r.fin              = 1'b0;
        return r;
    endfunction

    task automatic compact_ident(input logic [31:0] id, input logic lst);
        t_range_exp batch[$];
        logic       is_dup;
        is_dup = (held_cnt > 0) ? (id == held_new) : (run_open && id == run_last);
        if (!is_dup) begin
            if (run_open) begin
                if (id - run_last == run_step) begin
                    run_last = id;
                end else begin
                    batch.push_back(make_range(run_first, run_last, run_step));
                    run_open = 1'b0;
                    held_new = id;
                    held_cnt = 1;
                end
            end else if (held_cnt == 0) begin
                held_new = id;
                held_cnt = 1;
            end else if (held_cnt == 1) begin
                held_old = held_new;
                held_new = id;
                held_cnt = 2;
            end else if (held_new - held_old == id - held_new) begin
                run_open  = 1'b1;
                run_first = held_old;
                run_last  = id;
                run_step  = id - held_new;
                held_cnt  = 0;
            end else begin
                batch.push_back(make_range(held_old, held_old, 32'd1));
                held_old = held_new;
                held_new = id;
            end
        end
        if (lst) begin
            if (run_open)      batch.push_back(make_range(run_first, run_last, run_step));
            if (held_cnt >= 2) batch.push_back(make_range(held_old, held_old, 32'd1));
            if (held_cnt >= 1) batch.push_back(make_range(held_new, held_new, 32'd1));
            run_open = 1'b0;
            held_cnt = 0;
            if (batch.size() > 0) batch[batch.size()-1].fin = 1'b1;
        end
        foreach (batch[k]) range_q.push_back(batch[k]);
    endtask

    task automatic note_fail(input string what);
        if (o_fail_count < 10) begin
            $display("%0t: %s", $realtime, what);
        end
        o_fail_count = o_fail_count + 1;
    endtask

    always @(posedge i_clk) begin : watch
        t_range_exp want;
        if (!i_rst_n) begin
            range_q.delete();
            run_open  = 1'b0;
            run_first = '0;
            run_last  = '0;
            run_step  = '0;
            held_cnt  = 0;
            held_old  = '0;
            held_new  = '0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                compact_ident(i_req.ident, i_req.last_in);
            end
            if (i_rng.valid && i_rng.ready) begin
                if (range_q.size() == 0) begin
                    note_fail($sformatf("unexpected range first=%0d last=%0d step=%0d final=%0b",
                        i_rng.range_first, i_rng.range_last, i_rng.range_stride,
                        i_rng.final_out));
                end else begin
                    want = range_q.pop_front();
                    if (i_rng.range_first  !== want.rng.range_first ||
                        i_rng.range_last   !== want.rng.range_last ||
                        i_rng.range_stride !== want.rng.range_stride ||
                        i_rng.final_out    !== want.fin) begin
                        note_fail($sformatf({"range mismatch: expected first=%0d last=%0d",
                            " step=%0d final=%0b, got first=%0d last=%0d step=%0d final=%0b"},
                            $signed(want.rng.range_first), $signed(want.rng.range_last),
                            want.rng.range_stride, want.fin,
                            i_rng.range_first, i_rng.range_last, i_rng.range_stride,
                            i_rng.final_out));
                    end
                end
            end
        end
        o_outstanding = range_q.size();
    end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// testbench: drives identifier lists into the run compactor under varying back-pressure
// depends on: apc_pkg, apc_if, arith_progression_run_compactor, apc_range_checker
module testbench;

    logic i_clk;
    logic i_rst_n;

    apc_in_if  req_if();
    apc_out_if rng_if();

    int fail_count;
    int outstanding;

    // idle odds per cycle, in percent, changed per phase
    int send_idle_pct;
    int recv_idle_pct;

    int          idents_sent;
    logic [31:0] prev_ident;

    // hand-picked lists: {ident, last_in}
    localparam logic [32:0] DIRECTED_REQS [25] = '{
        // lone identifier 0 with last
        {32'd0, 1'b1},
        // run that begins at 0, right after a list that ended on 0
        {32'd0, 1'b0}, {32'd1, 1'b0}, {32'd2, 1'b0}, {32'd3, 1'b1},
        // repeat of a pending single, then two singles flushed
        {32'd5, 1'b0}, {32'd5, 1'b0}, {32'd7, 1'b1},
        // repeat of the run tail that carries last, still flushes the run
        {32'd20, 1'b0}, {32'd22, 1'b0}, {32'd24, 1'b0}, {32'd24, 1'b1},
        // most negative, zero, most positive: three singles
        {32'h8000_0000, 1'b0}, {32'd0, 1'b0}, {32'h7FFF_FFFF, 1'b1},
        // run of step 1 that wraps from the top of the range to the bottom
        {32'h7FFF_FFFE, 1'b0}, {32'h7FFF_FFFF, 1'b0}, {32'h8000_0000, 1'b1},
        // descending run, step taken modulo 2^32
        {32'd9, 1'b0}, {32'd6, 1'b0}, {32'd3, 1'b1},
        // run broken by an identifier off the progression
        {32'd1, 1'b0}, {32'd3, 1'b0}, {32'd5, 1'b0}, {32'd6, 1'b1}
    };

    arith_progression_run_compactor #(
        .ID_WIDTH (32)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (rng_if)
    );

    apc_range_checker range_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_if),
        .i_rng         (rng_if),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // receiver side: ready drops at random, odds set by the current phase
    initial begin
        rng_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rng_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // one request; called at a falling edge and returns at the falling edge after
    // the request was taken, with valid still high so back-to-back requests flow
    task automatic send_ident(input logic [31:0] id, input logic lst);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.ident   <= id;
        req_if.last_in <= lst;
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
        idents_sent = idents_sent + 1;
        prev_ident  = id;
    endtask

    // hold off the sender until every predicted range has come out
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        @(negedge i_clk);
        while (outstanding != 0) @(negedge i_clk);
    endtask

    // mostly small ascending steps, sometimes huge or negative ones that wrap
    function automatic logic [31:0] pick_step();
        case ($urandom_range(9)) inside
            [0:3]:   return 32'($urandom_range(1, 4));
            [4:6]:   return 32'($urandom_range(5, 1000));
            7:       return 32'($urandom());
            8:       return 32'h0 - 32'($urandom_range(1, 8));
            default: return 32'h8000_0000;
        endcase
    endfunction

    // one list: progressions with random content, step changes, repeats of the
    // latest identifier, and now and then a list of pure noise
    task automatic send_list();
        logic [31:0] cur;
        logic [31:0] step;
        int          len;
        int          k;
        int          r;
        logic        noise;
        len   = $urandom_range(1, 12);
        noise = ($urandom_range(7) == 0);
        case ($urandom_range(5))
            0:       cur = prev_ident;
            1:       cur = 32'h7FFF_FFFF - 32'($urandom_range(0, 40));
            2:       cur = 32'h8000_0000 + 32'($urandom_range(0, 40));
            3:       cur = 32'hFFFF_FFFF - 32'($urandom_range(0, 40));
            4:       cur = 32'($urandom_range(0, 40));
            default: cur = $urandom();
        endcase
        step = pick_step();
        for (k = 0; k < len; k++) begin
            if (k > 0) begin
                r = $urandom_range(99);
                if (noise) begin
                    cur = $urandom();
                end else if (r < 8) begin
                    // repeat of the latest identifier, dropped by the block
                end else if (r < 25) begin
                    step = pick_step();
                    cur  = cur + step;
                end else begin
                    cur = cur + step;
                end
            end
            send_ident(cur, k == len - 1);
        end
    endtask

    initial begin : stimulus
        int k;
        req_if.valid   = 1'b0;
        req_if.ident   = '0;
        req_if.last_in = 1'b0;
        i_rst_n        = 1'b0;
        send_idle_pct  = 23;
        recv_idle_pct  = 82;
        idents_sent    = 0;
        prev_ident     = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed lists under slow-receiver pressure
        for (k = 0; k < 25; k++) begin
            send_ident(DIRECTED_REQS[k][32:1], DIRECTED_REQS[k][0]);
        end
        wait_drained();

        // phase one: sender mostly busy, receiver mostly stalled
        while (idents_sent < 25 + 70) send_list();
        wait_drained();

        // phase two: sender mostly idle, receiver mostly ready
        send_idle_pct = 82;
        recv_idle_pct = 23;
        while (idents_sent < 25 + 155) send_list();
        wait_drained();

        // phase three: full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (idents_sent < 25 + 250) send_list();
        wait_drained();

        // keep the clock running to catch any range the block emits unasked
        repeat (16) @(negedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial begin
        #400000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
